[hdl/rcd_pkg.sv]
// ----------------------------------------------------------------------------
// rcd_pkg
// Shared types and constants for the reversible character deque.
// ----------------------------------------------------------------------------
package rcd_pkg;

  localparam int unsigned CH_W   = 8;
  localparam int unsigned POS_W  = 12;
  localparam int unsigned LEN_W  = 13;
  localparam int unsigned STAT_W = 2;

  typedef enum logic [1:0] {
    FN_CLEAR  = 2'd0,
    FN_TOGGLE = 2'd1,
    FN_INSERT = 2'd2,
    FN_READ   = 2'd3
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

endpackage

[hdl/rcd_ram.sv]
// ----------------------------------------------------------------------------
// rcd_ram
// Ring storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rcd_ram #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = 12
) (
  input  logic                    clk,
  input  logic                    we,
  input  logic [AW-1:0]           waddr,
  input  logic [rcd_pkg::CH_W-1:0] wdata,
  input  logic                    re,
  input  logic [AW-1:0]           raddr,
  output logic [rcd_pkg::CH_W-1:0] rdata
);

  logic [rcd_pkg::CH_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // rdata holds until the next read, so a stalled result keeps its byte
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/reversible_char_deque_top.sv]
// ----------------------------------------------------------------------------
// reversible_char_deque_top
// Byte deque in a ring memory with a lazy reversal flag.
// ----------------------------------------------------------------------------
//  channel | handshake            | fields
//  --------+----------------------+-------------------------------
//  req     | req_valid/req_ready  | func, side, ch, position
//  rsp     | rsp_valid/rsp_ready  | data, status, length
//
// One transaction per cycle sustained while rsp_ready stays high; a result is
// registered first with the memory read in stage 1, then in the output register.
// Pointers and the reversal flag update at request accept, so back-to-back
// inserts and reads need no forwarding: the write lands before the next read
// samples the ring. Reset clears pointers, count and flag; ring contents are
// left as they are. A stalled response holds the second stage and then the
// request side.
// ----------------------------------------------------------------------------
module reversible_char_deque_top #(
  parameter int unsigned DEPTH = 4096
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  output logic                       req_ready,
  input  logic [1:0]                 func,
  input  logic                       side,
  input  logic [rcd_pkg::CH_W-1:0]   ch,
  input  logic [rcd_pkg::POS_W-1:0]  position,
  output logic                       rsp_valid,
  input  logic                       rsp_ready,
  output logic [rcd_pkg::CH_W-1:0]   data,
  output logic [rcd_pkg::STAT_W-1:0] status,
  output logic [rcd_pkg::LEN_W-1:0]  length
);

  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = (CW > rcd_pkg::POS_W) ? CW : rcd_pkg::POS_W;
  localparam logic [AW:0]   DEPTH_S = (AW+1)'(DEPTH);
  localparam logic [AW-1:0] LAST    = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_C  = CW'(DEPTH);

  // architectural state
  logic [AW-1:0] head, head_next;
  logic [CW-1:0] count, count_next;
  logic          rev, rev_next;

  // stage 1: waiting on memory read data
  logic                      s1_valid;
  logic                      s1_rd;
  rcd_pkg::status_t          s1_status;
  logic [rcd_pkg::LEN_W-1:0] s1_length;

  logic acc, out_free, s1_adv;
  rcd_pkg::status_t st_next;

  // memory port
  logic                     we, re;
  logic [AW-1:0]            waddr, raddr;
  logic [rcd_pkg::CH_W-1:0] rdata;

  // address arithmetic
  logic [AW-1:0]   head_dec, tail, rd_addr;
  logic [AW:0]     tail_sum, rd_sum;
  logic [CMPW-1:0] pos_w, cnt_w, off_w;
  logic            in_range, full, at_front;

  assign out_free  = !rsp_valid || rsp_ready;
  assign s1_adv    = s1_valid && out_free;
  assign req_ready = !s1_valid || out_free;
  assign acc       = req_valid && req_ready;

  always_comb begin
    full     = (count == FULL_C);
    at_front = (side == 1'b0) ^ rev;
    head_dec = (head == '0) ? LAST : head - AW'(1);

    tail_sum = (AW+1)'(head) + (AW+1)'(count);
    tail     = (tail_sum >= DEPTH_S) ? AW'(tail_sum - DEPTH_S) : tail_sum[AW-1:0];

    pos_w    = CMPW'(position);
    cnt_w    = CMPW'(count);
    in_range = (pos_w < cnt_w);
    // reads count from the physical back while reversed
    off_w    = rev ? (cnt_w - CMPW'(1) - pos_w) : pos_w;
    rd_sum   = (AW+1)'(head) + (AW+1)'(off_w[AW-1:0]);
    rd_addr  = (rd_sum >= DEPTH_S) ? AW'(rd_sum - DEPTH_S) : rd_sum[AW-1:0];
  end

  always_comb begin
    head_next  = head;
    count_next = count;
    rev_next   = rev;
    st_next    = rcd_pkg::ST_OK;
    we         = 1'b0;
    waddr      = tail;
    re         = 1'b0;
    raddr      = rd_addr;
    unique case (rcd_pkg::func_t'(func))
      rcd_pkg::FN_CLEAR: begin
        head_next  = '0;
        count_next = '0;
        rev_next   = 1'b0;
      end
      rcd_pkg::FN_TOGGLE: begin
        rev_next = !rev;
      end
      rcd_pkg::FN_INSERT: begin
        if (full) begin
          st_next = rcd_pkg::ST_FULL;
        end else begin
          we         = acc;
          count_next = count + CW'(1);
          if (at_front) begin
            head_next = head_dec;
            waddr     = head_dec;
          end
        end
      end
      rcd_pkg::FN_READ: begin
        if (in_range) begin
          re = acc;
        end else begin
          st_next = rcd_pkg::ST_RANGE;
        end
      end
      default: begin
        st_next = rcd_pkg::ST_OK;
      end
    endcase
  end

  rcd_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (ch),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
      rev   <= 1'b0;
    end else if (acc) begin
      head  <= head_next;
      count <= count_next;
      rev   <= rev_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (acc) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_rd     <= re;
      s1_status <= st_next;
      s1_length <= rcd_pkg::LEN_W'(count_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s1_adv) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      data   <= s1_rd ? rdata : '0;
      status <= s1_status;
      length <= s1_length;
    end
  end

endmodule

[hdl/rcd_checker.sv]
// ----------------------------------------------------------------------------
// rcd_checker
// Port-level checks on the deque's response channel.
// ----------------------------------------------------------------------------
module rcd_checker #(
  parameter int unsigned DEPTH = 4096
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       rsp_valid,
  input logic                       rsp_ready,
  input logic [rcd_pkg::CH_W-1:0]   data,
  input logic [rcd_pkg::STAT_W-1:0] status,
  input logic [rcd_pkg::LEN_W-1:0]  length
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(data) && $stable(status)
      && $stable(length))
    else $error("response changed while stalled");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status != rcd_pkg::ST_OK) |-> (data == '0))
    else $error("failed transaction carries data");

  a_full_len: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status == rcd_pkg::ST_FULL) |-> (length == rcd_pkg::LEN_W'(DEPTH)))
    else $error("insert dropped while not full");

  a_rst_idle: assert property (@(posedge clk)
    $past(rst) |-> !rsp_valid)
    else $error("response valid right after reset");

endmodule

bind reversible_char_deque_top rcd_checker #(
  .DEPTH (DEPTH)
) u_rcd_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .data      (data),
  .status    (status),
  .length    (length)
);
